// File: sv/char_lcd_nibble_write_sequencer_assert.svh
// Assertion helpers shared by the sequencer RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCDSEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_POS   = 2'd2,
    ACT_INIT  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HI       = 3'd1,
    PH_LO_SETUP = 3'd2,
    PH_LO       = 3'd3,
    PH_SETTLE   = 3'd4,
    PH_INIT_NIB = 3'd5,
    PH_LONG     = 3'd6
  } phase_t;

  // Register indexes on the config write channel
  localparam logic [2:0] CFG_PULSE_TICKS     = 3'd0;
  localparam logic [2:0] CFG_SETTLE_TICKS    = 3'd1;
  localparam logic [2:0] CFG_LONG_WAIT_TICKS = 3'd2;
  localparam logic [2:0] CFG_INIT_FUNCTION   = 3'd3;
  localparam logic [2:0] CFG_INIT_DISPLAY    = 3'd4;
  localparam logic [2:0] CFG_SET_ADDR_BASE   = 3'd5;
  localparam logic [2:0] CFG_SECOND_ROW_BASE = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Lone nibble of the wake-up function set (upper half of 0x20)
  localparam logic [3:0] INIT_NIBBLE = 4'h2;

  typedef struct packed {
    logic [19:0] pulse_ticks;
    logic [19:0] settle_ticks;
    logic [23:0] long_wait_ticks;
    logic [7:0]  init_function_word;
    logic [7:0]  init_display_word;
    logic [7:0]  set_address_base;
    logic [6:0]  second_row_base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_ticks:        20'd1000,
    settle_ticks:       20'd1000,
    long_wait_ticks:    24'd10000,
    init_function_word: 8'h28,
    init_display_word:  8'h0C,
    set_address_base:   8'h80,
    second_row_base:    7'h40
  };

endpackage

`default_nettype wire

// File: sv/lcdseq_regs.sv
`default_nettype none

module lcdseq_regs
  import lcdseq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                        cfg
);

  cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_PULSE_TICKS:     regs.pulse_ticks        <= wr_data[19:0];
        CFG_SETTLE_TICKS:    regs.settle_ticks       <= wr_data[19:0];
        CFG_LONG_WAIT_TICKS: regs.long_wait_ticks    <= wr_data[23:0];
        CFG_INIT_FUNCTION:   regs.init_function_word <= wr_data[7:0];
        CFG_INIT_DISPLAY:    regs.init_display_word  <= wr_data[7:0];
        CFG_SET_ADDR_BASE:   regs.set_address_base   <= wr_data[7:0];
        CFG_SECOND_ROW_BASE: regs.second_row_base    <= wr_data[6:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/char_lcd_nibble_write_sequencer.sv
// Character LCD write sequencer for a 4-bit (D7..D4) bus. Every input request
// is either a tick (the timebase) or a command: write byte, set cursor
// position, or start the init sequence. Commands are taken only while idle;
// a command that arrives busy, or a position with row > 1 or column >=
// COLUMNS, is dropped and flagged in its result. A byte goes out high nibble
// then low nibble, enable high for pulse_ticks ticks each with one low tick
// between, then settle_ticks of quiet. Init sends a lone 0x2 nibble, then
// the function-set and display-on words, each followed by long_wait_ticks.
// Every request yields exactly one result: pin levels, busy and rejected, as
// they stand after the request. Throughput is one request per clock: the
// sequencer state is updated in a single pass as a request is accepted
// (one counter increment and limit compare is the longest path), and the
// result sits in one output register. A new request is taken whenever that
// register is empty or being drained in the same cycle, so a stalled output
// holds off the input after one result. Timing limits saturate at
// 2^COUNT_WIDTH-1; a limit of zero behaves as one. Config writes are taken
// in any cycle (cfg_ready is always high) but are meant for idle periods.
`default_nettype none

`include "char_lcd_nibble_write_sequencer_assert.svh"

module char_lcd_nibble_write_sequencer
  import lcdseq_pkg::*;
#(
  parameter int COLUMNS     = 16,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [23:0]            s_tdata,  // byte_value[7:0], command_flags[15:8],
                                                // row[17:16], column[22:18], zero[23]
  input  wire logic [2:0]             s_tuser,  // action[1:0], rs_select[2]
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata,  // lcd_rs[0], lcd_en[1], lcd_nibble[5:2],
                                                // busy_res[6], rejected[7]
  // config writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Compare width wide enough for both the counter and the 24-bit limits
  localparam int LW = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  lcdseq_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // ---------------- sequencer state ----------------
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   rs_latch, rs_latch_next;
  logic [1:0]             init_step, init_step_next;
  logic [3:0]             pin_nibble, pin_nibble_next;
  logic                   en_level, en_level_next;

  logic       accept;
  action_t    act;
  logic       rs_sel;
  logic [7:0] byte_value, command_flags;
  logic [1:0] row;
  logic [4:0] column;

  assign accept        = s_tvalid & s_tready;
  assign act           = action_t'(s_tuser[1:0]);
  assign rs_sel        = s_tuser[2];
  assign byte_value    = s_tdata[7:0];
  assign command_flags = s_tdata[15:8];
  assign row           = s_tdata[17:16];
  assign column        = s_tdata[22:18];

  // Output slot is free, or is being emptied this cycle
  assign s_tready = ~m_tvalid | m_tready;

  // Saturating tick counter and limit compares. Once the counter sits at
  // its maximum every phase ends, which covers limits beyond its range.
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   cnt_sat;
  logic                   hit_pulse, hit_settle, hit_long;

  assign cnt_sat    = &tick_count;
  assign cnt_inc    = cnt_sat ? tick_count : tick_count + 1'b1;
  assign hit_pulse  = (LW'(cnt_inc) >= LW'(cfg.pulse_ticks))     || (&cnt_inc);
  assign hit_settle = (LW'(cnt_inc) >= LW'(cfg.settle_ticks))    || (&cnt_inc);
  assign hit_long   = (LW'(cnt_inc) >= LW'(cfg.long_wait_ticks)) || (&cnt_inc);

  // Cursor command: base OR (row base + column), row 0 base is zero
  logic [6:0] row_base;
  logic [7:0] pos_word;
  logic       pos_bad;

  assign row_base = row[0] ? cfg.second_row_base : 7'd0;
  assign pos_word = cfg.set_address_base | (8'(row_base) + 8'(column));
  assign pos_bad  = row[1] || (32'(column) >= 32'(COLUMNS));

  logic       rejected;
  logic       start_byte;
  logic [7:0] start_word;
  logic       start_rs;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    shift_byte_next = shift_byte;
    rs_latch_next   = rs_latch;
    init_step_next  = init_step;
    pin_nibble_next = pin_nibble;
    en_level_next   = en_level;
    rejected        = 1'b0;
    start_byte      = 1'b0;
    start_word      = 8'd0;
    start_rs        = 1'b0;

    if (accept) begin
      if (act == ACT_TICK) begin
        if (phase != PH_IDLE) begin
          tick_count_next = cnt_inc;
          case (phase)
            PH_HI: begin
              if (hit_pulse) begin
                en_level_next   = 1'b0;
                pin_nibble_next = shift_byte[3:0];
                phase_next      = PH_LO_SETUP;
                tick_count_next = '0;
              end
            end
            PH_LO_SETUP: begin
              // one low tick between the two strobes
              en_level_next   = 1'b1;
              phase_next      = PH_LO;
              tick_count_next = '0;
            end
            PH_LO: begin
              if (hit_pulse) begin
                en_level_next   = 1'b0;
                phase_next      = PH_SETTLE;
                tick_count_next = '0;
              end
            end
            PH_SETTLE: begin
              if (hit_settle) begin
                tick_count_next = '0;
                phase_next      = (init_step != 2'd0) ? PH_LONG : PH_IDLE;
              end
            end
            PH_INIT_NIB: begin
              if (hit_pulse) begin
                en_level_next   = 1'b0;
                phase_next      = PH_LONG;
                tick_count_next = '0;
              end
            end
            PH_LONG: begin
              if (hit_long) begin
                if (init_step == 2'd0) begin
                  start_byte     = 1'b1;
                  start_word     = cfg.init_function_word;
                  init_step_next = 2'd1;
                end else if (init_step == 2'd1) begin
                  start_byte     = 1'b1;
                  start_word     = cfg.init_display_word;
                  init_step_next = 2'd2;
                end else begin
                  init_step_next  = 2'd0;
                  tick_count_next = '0;
                  phase_next      = PH_IDLE;
                end
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              tick_count_next = '0;
              en_level_next   = 1'b0;
              init_step_next  = 2'd0;
            end
          endcase
        end
      end else if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        case (act)
          ACT_WRITE: begin
            start_byte = 1'b1;
            start_word = rs_sel ? byte_value : (byte_value | command_flags);
            start_rs   = rs_sel;
          end
          ACT_POS: begin
            if (pos_bad) begin
              rejected = 1'b1;
            end else begin
              start_byte = 1'b1;
              start_word = pos_word;
            end
          end
          ACT_INIT: begin
            rs_latch_next   = 1'b0;
            pin_nibble_next = INIT_NIBBLE;
            en_level_next   = 1'b1;
            tick_count_next = '0;
            init_step_next  = 2'd0;
            phase_next      = PH_INIT_NIB;
          end
          default: ;
        endcase
      end

      if (start_byte) begin
        shift_byte_next = start_word;
        rs_latch_next   = start_rs;
        pin_nibble_next = start_word[7:4];
        en_level_next   = 1'b1;
        tick_count_next = '0;
        phase_next      = PH_HI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      shift_byte <= '0;
      rs_latch   <= 1'b0;
      init_step  <= 2'd0;
      pin_nibble <= '0;
      en_level   <= 1'b0;
    end else begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      shift_byte <= shift_byte_next;
      rs_latch   <= rs_latch_next;
      init_step  <= init_step_next;
      pin_nibble <= pin_nibble_next;
      en_level   <= en_level_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {rejected, phase_next != PH_IDLE, pin_nibble_next,
                  en_level_next, rs_latch_next};
    end
  end

  // ---------------- checks ----------------
  `LCDSEQ_ASSERT_IMP(a_idle_en_low, phase == PH_IDLE, !en_level,
    "enable high while idle")
  `LCDSEQ_ASSERT_IMP(a_init_step_busy, init_step != 2'd0, phase != PH_IDLE,
    "init step left set after sequence ended")
  `LCDSEQ_ASSERT_IMP(a_lo_setup_gap, phase == PH_LO_SETUP,
    !en_level && tick_count == '0, "no low gap between nibble strobes")
  `LCDSEQ_ASSERT_NEXT(a_busy_reject,
    accept && act != ACT_TICK && phase != PH_IDLE,
    m_tvalid && m_tdata[7] && phase == $past(phase),
    "request while busy not rejected")

endmodule

`default_nettype wire
